FILE: hdl/ggcd_pkg.sv
`default_nettype none
package ggcd_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 24;

    localparam int LAT_W  = 24;
    localparam int IN_W   = 25;
    localparam int OUT_W  = 15;

    // degrees scaled by 3*2^F, then radians in Q30
    localparam int D_W    = IN_W + 3;
    localparam int PIK_W  = 34;
    localparam int PROD_W = D_W + PIK_W;
    localparam int RAD_SH = FRAC_BITS + 10;
    localparam int RAD_W  = PROD_W - RAD_SH;
    localparam int ANG_W  = RAD_W + 1;

    // CORDIC datapath and argument products
    localparam int CW     = 34;
    localparam int MW     = 2 * CW;

    // square root
    localparam int AC_W      = 31;
    localparam int SR_W      = 61;
    localparam int R_W       = 31;
    localparam int SQ_STAGES = 31;
    localparam int TAG_W     = AC_W + 1;

    // distance scaling
    localparam int TH_W   = 32;
    localparam int EM_W   = 23;
    localparam int E_W    = TH_W + EM_W;
    localparam int T_W    = E_W - 30;
    localparam int DIV_K  = 35;
    localparam int DIV_MW = 26;
    localparam int R2_W   = T_W + DIV_MW;

    // result queue
    localparam int FIFO_DEPTH = 128;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CRED_W     = FIFO_AW + 1;

    localparam logic [63:0] PIK         = (64'd3141592 << 40) / 64'd540000000;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q60_ONE     = 64'd1 << 60;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_FOUR_PI = 64'd13493037704;
    localparam logic [63:0] CORDIC_GAIN = 64'd652032874;
    localparam logic [63:0] EARTH_MM    = 64'd6378388;
    localparam logic [63:0] DIV_M       = ((64'd1 << DIV_K) + 64'd999) / 64'd1000;

    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/geo_great_circle_distance_core.sv
`default_nettype none
// Great-circle distance (TSP GEO metric) between two DDD.MM points, in whole km.
// Fully pipelined: one point pair is accepted per cycle while o_in_ready is
// high. The datapath is a chain of cells: 24 CORDIC rotation cells for each
// of the three cosines, 31 square-root cells and 24 CORDIC vectoring cells for
// the acos, plus multiply and reduction stages. Results collect in a 128-entry
// RAM queue; up to 128 items may be outstanding, so a stalled consumer blocks
// input only once that many are in flight.
module geo_great_circle_distance_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [ggcd_pkg::LAT_W-1:0]  i_lat_a,
    input  wire logic signed [ggcd_pkg::IN_W-1:0]   i_lon_a,
    input  wire logic signed [ggcd_pkg::LAT_W-1:0]  i_lat_b,
    input  wire logic signed [ggcd_pkg::IN_W-1:0]   i_lon_b,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic             [ggcd_pkg::OUT_W-1:0]  o_distance_km
);
    import ggcd_pkg::*;

    localparam int CS = CORDIC_STAGES;
    localparam int SS = SQ_STAGES;

    logic signed [RAD_W-1:0] rad_la;
    logic signed [RAD_W-1:0] rad_oa;
    logic signed [RAD_W-1:0] rad_lb;
    logic signed [RAD_W-1:0] rad_ob;

    logic in_acc;
    logic r_v_r0, r_v_r1, r_v_p0, r_v_p1, r_v_p2, r_v_q;
    logic r_v_m1, r_v_m2, r_v_m3, r_v_m4, r_v_m5;
    logic r_v_th, r_v_d1, r_v_d2, r_v_d3;

    logic signed [ANG_W-1:0] r_a [3];
    logic        [ANG_W-1:0] r_m [3];
    logic signed [CW-1:0]    r_pz [3];
    logic                    r_pn [3];
    logic        [ANG_W-1:0] n_m [3];
    logic        [ANG_W-1:0] m0;
    logic        [ANG_W-1:0] rr [3];
    logic        [ANG_W-1:0] zz [3];
    logic                    nn [3];

    logic signed [CW-1:0] cx    [3][CS+1];
    logic signed [CW-1:0] cy    [3][CS+1];
    logic signed [CW-1:0] cz    [3][CS+1];
    logic                 cside [3][CS+1];
    logic                 cvld  [3][CS+1];

    logic signed [CW-1:0] r_q [3];
    logic signed [CW-1:0] r_ma, r_mb, r_mq2, r_mq3;
    logic signed [MW-1:0] r_p1, r_p2;
    logic signed [MW-1:0] diff, arg, lim;
    logic signed [CW-1:0] n_c, r_c;
    logic [AC_W-1:0]      r_ac4, r_ac5;
    logic                 r_cn4, r_cn5;
    logic [2*AC_W-1:0]    sq;
    logic [SR_W-1:0]      r_n;

    logic [SR_W-1:0]  srem  [SS+1];
    logic [R_W-1:0]   sroot [SS+1];
    logic [TAG_W-1:0] stag  [SS+1];
    logic             svld  [SS+1];

    logic signed [CW-1:0] ax    [CS+1];
    logic signed [CW-1:0] ay    [CS+1];
    logic signed [CW-1:0] az    [CS+1];
    logic                 aside [CS+1];
    logic                 avld  [CS+1];

    logic signed [CW-1:0] zc;
    logic [TH_W-1:0]      n_th, r_th;
    logic [E_W-1:0]       r_e;
    logic [R2_W-1:0]      r_r2;
    logic [OUT_W-1:0]     r_dist;

    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [CRED_W-1:0]  r_cnt, r_cred;
    logic               r_ov;
    logic               fifo_rd, deliver;

    assign o_in_ready = (r_cred < CRED_W'(FIFO_DEPTH));
    assign in_acc     = i_in_valid & o_in_ready;

    ggcd_rad u_rad_la (.i_clk(i_clk), .i_v(IN_W'(i_lat_a)), .o_rad(rad_la));
    ggcd_rad u_rad_oa (.i_clk(i_clk), .i_v(i_lon_a),        .o_rad(rad_oa));
    ggcd_rad u_rad_lb (.i_clk(i_clk), .i_v(IN_W'(i_lat_b)), .o_rad(rad_lb));
    ggcd_rad u_rad_ob (.i_clk(i_clk), .i_v(i_lon_b),        .o_rad(rad_ob));

    // angle reduction: |a| mod 2pi, fold to [0,pi], then to [0,pi/2] with sign
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            m0 = r_a[l][ANG_W-1] ? ANG_W'(-r_a[l]) : ANG_W'(r_a[l]);
            if (m0 >= ANG_W'(Q30_FOUR_PI)) begin
                m0 = m0 - ANG_W'(Q30_FOUR_PI);
            end
            if (m0 >= ANG_W'(Q30_TWO_PI)) begin
                m0 = m0 - ANG_W'(Q30_TWO_PI);
            end
            n_m[l] = m0;
            rr[l]  = (r_m[l] > ANG_W'(Q30_PI)) ? ANG_W'(Q30_TWO_PI) - r_m[l] : r_m[l];
            nn[l]  = (rr[l] > ANG_W'(Q30_HALF_PI));
            zz[l]  = nn[l] ? ANG_W'(Q30_PI) - rr[l] : rr[l];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0] <= ANG_W'(rad_oa) - ANG_W'(rad_ob);
        r_a[1] <= ANG_W'(rad_la) - ANG_W'(rad_lb);
        r_a[2] <= ANG_W'(rad_la) + ANG_W'(rad_lb);
        for (int l = 0; l < 3; l++) begin
            r_m[l]  <= n_m[l];
            r_pz[l] <= signed'(CW'(zz[l]));
            r_pn[l] <= nn[l];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_cos
        assign cx[l][0]    = signed'(CW'(CORDIC_GAIN));
        assign cy[l][0]    = '0;
        assign cz[l][0]    = r_pz[l];
        assign cside[l][0] = r_pn[l];
        assign cvld[l][0]  = r_v_p2;
        for (genvar i = 0; i < CS; i++) begin : g_cell
            ggcd_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_vec  (1'b0),
                .i_k    (5'(i)),
                .i_vld  (cvld[l][i]),
                .i_side (cside[l][i]),
                .i_x    (cx[l][i]),
                .i_y    (cy[l][i]),
                .i_z    (cz[l][i]),
                .o_vld  (cvld[l][i+1]),
                .o_side (cside[l][i+1]),
                .o_x    (cx[l][i+1]),
                .o_y    (cy[l][i+1]),
                .o_z    (cz[l][i+1])
            );
        end
    end

    // argument 0.5*((1+q1)*q2 - (1-q1)*q3), clamped, then |c| and 1 - c*c
    always_comb begin
        lim  = signed'(MW'(Q30_ONE));
        diff = r_p1 - r_p2;
        arg  = diff >>> 31;
        if (arg > lim) begin
            arg = lim;
        end
        if (arg < -lim) begin
            arg = -lim;
        end
        n_c = CW'(arg);
        sq  = (2*AC_W)'(r_ac4) * (2*AC_W)'(r_ac4);
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_q[l] <= cside[l][CS] ? -cx[l][CS] : cx[l][CS];
        end
        r_ma  <= signed'(CW'(Q30_ONE)) + r_q[0];
        r_mb  <= signed'(CW'(Q30_ONE)) - r_q[0];
        r_mq2 <= r_q[1];
        r_mq3 <= r_q[2];
        r_p1  <= MW'(r_ma) * MW'(r_mq2);
        r_p2  <= MW'(r_mb) * MW'(r_mq3);
        r_c   <= n_c;
        r_ac4 <= r_c[CW-1] ? AC_W'(-r_c) : AC_W'(r_c);
        r_cn4 <= r_c[CW-1];
        r_n   <= SR_W'(Q60_ONE - 64'(sq));
        r_ac5 <= r_ac4;
        r_cn5 <= r_cn4;
    end

    assign srem[0]  = r_n;
    assign sroot[0] = '0;
    assign stag[0]  = {r_cn5, r_ac5};
    assign svld[0]  = r_v_m5;

    for (genvar i = 0; i < SS; i++) begin : g_sqrt
        ggcd_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_j    (5'(SS - 1 - i)),
            .i_vld  (svld[i]),
            .i_rem  (srem[i]),
            .i_root (sroot[i]),
            .i_tag  (stag[i]),
            .o_vld  (svld[i+1]),
            .o_rem  (srem[i+1]),
            .o_root (sroot[i+1]),
            .o_tag  (stag[i+1])
        );
    end

    assign ax[0]    = signed'(CW'(stag[SS][AC_W-1:0]));
    assign ay[0]    = signed'(CW'(sroot[SS]));
    assign az[0]    = '0;
    assign aside[0] = stag[SS][AC_W];
    assign avld[0]  = svld[SS];

    for (genvar i = 0; i < CS; i++) begin : g_acos
        ggcd_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vec  (1'b1),
            .i_k    (5'(i)),
            .i_vld  (avld[i]),
            .i_side (aside[i]),
            .i_x    (ax[i]),
            .i_y    (ay[i]),
            .i_z    (az[i]),
            .o_vld  (avld[i+1]),
            .o_side (aside[i+1]),
            .o_x    (ax[i+1]),
            .o_y    (ay[i+1]),
            .o_z    (az[i+1])
        );
    end

    // theta, then floor(theta*6378388 / 2^30 / 1000) + 1 by reciprocal
    always_comb begin
        zc   = az[CS][CW-1] ? '0 : az[CS];
        n_th = aside[CS] ? TH_W'(Q30_PI) - TH_W'(zc) : TH_W'(zc);
    end

    always_ff @(posedge i_clk) begin
        r_th   <= n_th;
        r_e    <= E_W'(r_th) * E_W'(EARTH_MM);
        r_r2   <= R2_W'(r_e[E_W-1:30]) * R2_W'(DIV_M);
        r_dist <= OUT_W'(r_r2 >> DIV_K) + OUT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_r0 <= 1'b0;
            r_v_r1 <= 1'b0;
            r_v_p0 <= 1'b0;
            r_v_p1 <= 1'b0;
            r_v_p2 <= 1'b0;
            r_v_q  <= 1'b0;
            r_v_m1 <= 1'b0;
            r_v_m2 <= 1'b0;
            r_v_m3 <= 1'b0;
            r_v_m4 <= 1'b0;
            r_v_m5 <= 1'b0;
            r_v_th <= 1'b0;
            r_v_d1 <= 1'b0;
            r_v_d2 <= 1'b0;
            r_v_d3 <= 1'b0;
        end else begin
            r_v_r0 <= in_acc;
            r_v_r1 <= r_v_r0;
            r_v_p0 <= r_v_r1;
            r_v_p1 <= r_v_p0;
            r_v_p2 <= r_v_p1;
            r_v_q  <= cvld[0][CS] & cvld[1][CS] & cvld[2][CS];
            r_v_m1 <= r_v_q;
            r_v_m2 <= r_v_m1;
            r_v_m3 <= r_v_m2;
            r_v_m4 <= r_v_m3;
            r_v_m5 <= r_v_m4;
            r_v_th <= avld[CS];
            r_v_d1 <= r_v_th;
            r_v_d2 <= r_v_d1;
            r_v_d3 <= r_v_d2;
        end
    end

    // result queue; credits count every item accepted and not yet delivered
    assign deliver = r_ov & i_out_ready;
    assign fifo_rd = (r_cnt != '0) && (!r_ov || i_out_ready);

    ggcd_ram #(
        .WIDTH(OUT_W),
        .DEPTH(FIFO_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (r_v_d3),
        .i_waddr(r_wptr),
        .i_wdata(r_dist),
        .i_re   (fifo_rd),
        .i_raddr(r_rptr),
        .o_rdata(o_distance_km)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_cred <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_v_d3) begin
                r_wptr <= r_wptr + FIFO_AW'(1);
            end
            if (fifo_rd) begin
                r_rptr <= r_rptr + FIFO_AW'(1);
            end
            r_cnt  <= r_cnt + CRED_W'(r_v_d3) - CRED_W'(fifo_rd);
            r_cred <= r_cred + CRED_W'(in_acc) - CRED_W'(deliver);
            if (fifo_rd) begin
                r_ov <= 1'b1;
            end else if (deliver) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;

endmodule
`default_nettype wire

FILE: hdl/ggcd_ram.sv
`default_nettype none
module ggcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hdl/ggcd_rad.sv
`default_nettype none
module ggcd_rad (
    input  wire logic                              i_clk,
    input  wire logic signed [ggcd_pkg::IN_W-1:0]  i_v,
    output logic signed      [ggcd_pkg::RAD_W-1:0] o_rad
);
    import ggcd_pkg::*;

    localparam logic signed [PIK_W-1:0] PIK_S = PIK[PIK_W-1:0];

    logic signed [D_W-1:0]    vx;
    logic signed [D_W-1:0]    q;
    logic signed [D_W-1:0]    mins;
    logic signed [D_W-1:0]    n_d;
    logic signed [D_W-1:0]    r_d;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;

    // whole degrees truncated toward zero; d = 3*deg*2^F + 5*min = 3*v + 2*min
    always_comb begin
        vx = D_W'(i_v);
        q  = vx >>> FRAC_BITS;
        if (i_v[IN_W-1] && (i_v[FRAC_BITS-1:0] != '0)) begin
            q = q + D_W'(1);
        end
        mins   = vx - (q <<< FRAC_BITS);
        n_d    = (vx <<< 1) + vx + (mins <<< 1);
        n_prod = PROD_W'(r_d) * PROD_W'(PIK_S);
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_prod <= n_prod;
    end

    assign o_rad = r_prod[PROD_W-1:RAD_SH];

endmodule
`default_nettype wire

FILE: hdl/ggcd_cordic_cell.sv
`default_nettype none
module ggcd_cordic_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vec,
    input  wire logic [4:0]                     i_k,
    input  wire logic                           i_vld,
    input  wire logic                           i_side,
    input  wire logic signed [ggcd_pkg::CW-1:0] i_x,
    input  wire logic signed [ggcd_pkg::CW-1:0] i_y,
    input  wire logic signed [ggcd_pkg::CW-1:0] i_z,
    output logic                                o_vld,
    output logic                                o_side,
    output logic signed      [ggcd_pkg::CW-1:0] o_x,
    output logic signed      [ggcd_pkg::CW-1:0] o_y,
    output logic signed      [ggcd_pkg::CW-1:0] o_z
);
    import ggcd_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic                 dir;
    logic                 cw;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;
    logic                 r_vld;
    logic                 r_side;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    // rotation steers by the sign of z, vectoring by the sign of y
    always_comb begin
        xs  = i_x >>> i_k;
        ys  = i_y >>> i_k;
        at  = CW'(atan_q30(i_k));
        dir = i_vec ? (i_y > 0) : ~i_z[CW-1];
        cw  = i_vec ? ~dir : dir;
        if (cw) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - at;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule
`default_nettype wire

FILE: hdl/ggcd_sqrt_cell.sv
`default_nettype none
module ggcd_sqrt_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [4:0]                   i_j,
    input  wire logic                         i_vld,
    input  wire logic [ggcd_pkg::SR_W-1:0]    i_rem,
    input  wire logic [ggcd_pkg::R_W-1:0]     i_root,
    input  wire logic [ggcd_pkg::TAG_W-1:0]   i_tag,
    output logic                              o_vld,
    output logic      [ggcd_pkg::SR_W-1:0]    o_rem,
    output logic      [ggcd_pkg::R_W-1:0]     o_root,
    output logic      [ggcd_pkg::TAG_W-1:0]   o_tag
);
    import ggcd_pkg::*;

    logic [4:0]      sh1;
    logic [5:0]      sh2;
    logic [SR_W:0]   trial;
    logic [SR_W-1:0] n_rem;
    logic [R_W-1:0]  n_root;
    logic            r_vld;
    logic [SR_W-1:0] r_rem;
    logic [R_W-1:0]  r_root;
    logic [TAG_W-1:0] r_tag;

    // (root + 2^j)^2 - root^2 = root*2^(j+1) + 2^(2j)
    always_comb begin
        sh1   = i_j + 5'd1;
        sh2   = {i_j, 1'b0};
        trial = ((SR_W+1)'(i_root) << sh1) + ((SR_W+1)'(1) << sh2);
        if ({1'b0, i_rem} >= trial) begin
            n_rem  = i_rem - trial[SR_W-1:0];
            n_root = i_root + (R_W'(1) << i_j);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_tag  <= i_tag;
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_tag  = r_tag;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
    import ggcd_pkg::*;

    class distance_board;
        int unsigned pending_km[$];
        longint      atan_tab[32];

        function void init_tab();
            atan_tab = '{
                64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                64'h00000001, 64'h00000000};
        endfunction

        function longint radians(longint v);
            longint one, deg, mins, d, pik;
            one  = 64'sd1 <<< FRAC_BITS;
            pik  = longint'((64'd3141592 << 40) / 64'd540000000);
            deg  = v / one;
            mins = v - deg * one;
            d    = 3 * deg * one + 5 * mins;
            return (d * pik) >>> (FRAC_BITS + 10);
        endfunction

        function longint rot_cos(longint z);
            longint x, y, xs, ys;
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                xs = x >>> (i & 31);
                ys = y >>> (i & 31);
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_tab[i & 31];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_tab[i & 31];
                end
            end
            return x;
        endfunction

        function longint cosine(longint a);
            longint r, pi_q, two_pi;
            pi_q   = 64'sd3373259426;
            two_pi = 64'sd6746518852;
            r = a % two_pi;
            if (r > pi_q) r = r - two_pi;
            if (r < -pi_q) r = r + two_pi;
            if (r < 0) r = -r;
            if (r > 64'sd1686629713) return -rot_cos(pi_q - r);
            return rot_cos(r);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint arc_cos(longint c);
            longint ac, x, y, z, xs, ys;
            ac = (c < 0) ? -c : c;
            x = ac;
            y = longint'(int_sqrt((64'd1 << 60) - longint'(ac * ac)));
            z = 0;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                xs = x >>> (i & 31);
                ys = y >>> (i & 31);
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + atan_tab[i & 31];
                end else begin
                    x = x - ys; y = y + xs; z = z - atan_tab[i & 31];
                end
            end
            if (z < 0) z = 0;
            return (c < 0) ? 64'sd3373259426 - z : z;
        endfunction

        function void note_pair(logic signed [LAT_W-1:0] la, logic signed [IN_W-1:0] oa,
                                logic signed [LAT_W-1:0] lb, logic signed [IN_W-1:0] ob);
            longint r_la, r_oa, r_lb, r_ob, q1, q2, q3, arg, one, theta;
            longint unsigned km;
            one  = 64'sd1 <<< 30;
            r_la = radians(longint'(la));
            r_oa = radians(longint'(oa));
            r_lb = radians(longint'(lb));
            r_ob = radians(longint'(ob));
            q1 = cosine(r_oa - r_ob);
            q2 = cosine(r_la - r_lb);
            q3 = cosine(r_la + r_lb);
            arg = ((one + q1) * q2 - (one - q1) * q3) >>> 31;
            if (arg > one) arg = one;
            if (arg < -one) arg = -one;
            theta = arc_cos(arg);
            km = (64'd6378388 * longint'(unsigned'(theta))) / (64'd1000 << 30) + 1;
            pending_km.push_back(int'(km & 64'h7FFF));
        endfunction

        // 0: ok, 1: nothing pending, 2: mismatch
        function int check_km(logic [OUT_W-1:0] km, output int unsigned want);
            want = 0;
            if (pending_km.size() == 0) return 1;
            want = pending_km.pop_front();
            return (want == km) ? 0 : 2;
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [LAT_W-1:0]  i_lat_a = '0;
    logic signed [IN_W-1:0]   i_lon_a = '0;
    logic signed [LAT_W-1:0]  i_lat_b = '0;
    logic signed [IN_W-1:0]   i_lon_b = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic        [OUT_W-1:0]  o_distance_km;

    distance_board board;
    int errors = 0;
    bit steady = 0;

    geo_great_circle_distance_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_lat_a(i_lat_a), .i_lon_a(i_lon_a), .i_lat_b(i_lat_b), .i_lon_b(i_lon_b),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_distance_km(o_distance_km)
    );

    always #6 i_clk = ~i_clk;

    task report(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        int rc;
        int unsigned want;
        if (i_rst_n && i_in_valid && o_in_ready)
            board.note_pair(i_lat_a, i_lon_a, i_lat_b, i_lon_b);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rc = board.check_km(o_distance_km, want);
            if (rc == 1) report($sformatf("unexpected item, km=%0d", o_distance_km));
            else if (rc == 2)
                report($sformatf("km got %0d want %0d", o_distance_km, want));
        end
    end

    task send_pair(int la, int oa, int lb, int ob);
        int n;
        n = steady ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_lat_a <= LAT_W'(la); i_lon_a <= IN_W'(oa);
        i_lat_b <= LAT_W'(lb); i_lon_b <= IN_W'(ob);
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    function int lat_rand();
        if ($urandom_range(0, 9) == 0) return int'($urandom());
        return int'($urandom_range(0, 2 * 5898240)) - 5898240;
    endfunction

    function int lon_rand();
        if ($urandom_range(0, 9) == 0) return int'($urandom());
        return int'($urandom_range(0, 2 * 11796480)) - 11796480;
    endfunction

    initial begin
        int la, oa, lb, ob;
        board = new();
        board.init_tab();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: zero, same point, antipodes, range limits, full-width limits
        send_pair(0, 0, 0, 0);
        send_pair(5898240, 11796480, 5898240, 11796480);
        send_pair(5898240, 0, -5898240, 0);
        send_pair(0, 0, 0, 11796480);
        send_pair(0, -11796480, 0, 11796480);
        send_pair(-5898240, -11796480, 5898240, 11796480);
        send_pair(-8388608, -16777216, 8388607, 16777215);
        send_pair(8388607, 16777215, -8388608, -16777216);
        send_pair(8388607, 16777215, 8388607, 16777215);
        send_pair(-8388608, -16777216, -8388608, -16777216);
        send_pair(32'h3A_0000, 32'h3B_FFFF, -32'h3A_0000, -32'h3B_FFFF);
        send_pair(1, -1, -1, 1);
        send_pair(0, 1, 0, 0);
        send_pair(0, 11796480, 0, -11796479);
        send_pair(2949120, 5898240, -2949120, -5898240);
        send_pair(32'h26_3B00, 32'h08_1E00, 32'h33_0000, 32'hFF8A_0000);
        for (int i = 0; i < 1300; i++) begin
            if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            la = lat_rand(); oa = lon_rand();
            case ($urandom_range(0, 3))
                0: begin
                    lb = la + int'($urandom_range(0, 400)) - 200;
                    ob = oa + int'($urandom_range(0, 400)) - 200;
                end
                1: begin
                    lb = -la;
                    ob = (oa > 0) ? oa - 11796480 : oa + 11796480;
                end
                default: begin
                    lb = lat_rand(); ob = lon_rand();
                end
            endcase
            send_pair(la, oa, lb, ob);
        end
        i_in_valid <= 1'b0;
        while (board.pending_km.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = steady ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin
        #(12 * 600000);
        $display("testbench NOT OK");
        $finish;
    end
endmodule
